@@ rtl/core/ptc_pkg.sv @@
// shared types and constants for the pressure/temperature compensation pipeline
package ptc_pkg;

   // calibration register indexes on the csr port
   typedef enum logic [2:0] {
      REG_SENS_BASE     = 3'd0,
      REG_OFFSET_BASE   = 3'd1,
      REG_SENS_TEMPCO   = 3'd2,
      REG_OFFSET_TEMPCO = 3'd3,
      REG_REF_TEMP      = 3'd4,
      REG_TEMP_COEF     = 3'd5
   } reg_index_type;

   // calibration words
   typedef struct packed {
      logic [15:0] sens_base;
      logic [15:0] offset_base;
      logic [15:0] sens_tempco;
      logic [15:0] offset_tempco;
      logic [15:0] ref_temp;
      logic [15:0] temp_coef;
   } cal_type;

   // item after the tempco products
   typedef struct packed {
      logic        [23:0] pressure_raw;
      logic signed [41:0] prod_temp;
      logic signed [41:0] prod_off;
      logic signed [41:0] prod_sens;
   } prod_type;

   // item after scaling and limiting
   typedef struct packed {
      logic        [23:0] pressure_raw;
      logic signed [17:0] temp_centideg;
      logic signed [35:0] off;
      logic signed [34:0] sens;
   } scale_type;

   // temperature difference limits
   localparam logic signed [24:0] DT_MIN = -25'sd16776960;
   localparam logic signed [24:0] DT_MAX = 25'sd16777215;

   // temperature base and output limits
   localparam logic signed [19:0] TEMP_BASE    = 20'sd2000;
   localparam logic signed [19:0] TEMP_OUT_MIN = -20'sd131072;
   localparam logic signed [19:0] TEMP_OUT_MAX = 20'sd131071;

   // offset and sensitivity limits
   localparam logic signed [36:0] OFF_MIN  = -37'sd17179344900;
   localparam logic signed [36:0] OFF_MAX  = 37'sd25769410560;
   localparam logic signed [35:0] SENS_MIN = -36'sd8589672450;
   localparam logic signed [35:0] SENS_MAX = 36'sd12884705280;

   // pressure output limits
   localparam logic signed [26:0] PRESS_OUT_MIN = -27'sd16777216;
   localparam logic signed [26:0] PRESS_OUT_MAX = 27'sd16777215;

endpackage

@@ rtl/core/pressure_temp_compensation.sv @@
// top level: calibration registers, stream ports and the compensation pipeline
// Takes a raw pressure/temperature pair every cycle unless back pressure stalls
// the flow, and returns the compensated temperature (0.01 degree) and pressure.
// It has six register stages: temperature difference, the three tempco
// multipliers, scaling with limits, the pressure product split into two partial
// multipliers, their recombination, and the offset removal into the output
// register. Each stage holds its item while the one after it is full, so back
// pressure on the result side stalls only as far back as there are full stages.
// The user must write calibration words on the csr port only while no item is
// in flight; the block does not enforce it. Indexes above five are ignored.
module pressure_temp_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // temp_centideg[17:0], pressure_comp[42:18], zero[47:43]
);

   ptc_pkg::cal_type    cal_ff;
   ptc_pkg::cal_type    cal_in;
   logic                prod_valid;
   logic                prod_ready;
   ptc_pkg::prod_type   prod_item;
   logic                scale_valid;
   logic                scale_ready;
   ptc_pkg::scale_type  scale_item;
   logic signed [17:0]  temp_centideg;
   logic signed [24:0]  pressure_comp;

   // calibration register writes
   always_comb begin
      cal_in = cal_ff;
      if (csr_wen) begin
         case (csr_index)
            ptc_pkg::REG_SENS_BASE:     cal_in.sens_base     = csr_wdata;
            ptc_pkg::REG_OFFSET_BASE:   cal_in.offset_base   = csr_wdata;
            ptc_pkg::REG_SENS_TEMPCO:   cal_in.sens_tempco   = csr_wdata;
            ptc_pkg::REG_OFFSET_TEMPCO: cal_in.offset_tempco = csr_wdata;
            ptc_pkg::REG_REF_TEMP:      cal_in.ref_temp      = csr_wdata;
            ptc_pkg::REG_TEMP_COEF:     cal_in.temp_coef     = csr_wdata;
            default:                    cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // difference and products
   ptc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cal             (cal_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .pressure_raw    (req_tdata[23:0]),
      .temperature_raw (req_tdata[47:24]),
      .out_valid       (prod_valid),
      .out_ready       (prod_ready),
      .out_item        (prod_item)
   );

   // scaling and limits
   ptc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_item   (prod_item),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_item  (scale_item)
   );

   // pressure product and output register
   ptc_press u_press (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (scale_valid),
      .in_ready      (scale_ready),
      .in_item       (scale_item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .temp_centideg (temp_centideg),
      .pressure_comp (pressure_comp)
   );

   assign rsp_tdata = {5'b0, pressure_comp, temp_centideg};

endmodule

@@ rtl/core/ptc_front.sv @@
// temperature difference stage and the three tempco multiplier stage
module ptc_front (
   input  logic                clock,
   input  logic                reset,
   input  ptc_pkg::cal_type    cal,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [23:0]         pressure_raw,
   input  logic [23:0]         temperature_raw,
   output logic                out_valid,
   input  logic                out_ready,
   output ptc_pkg::prod_type   out_item
);

   logic                s1_valid_ff;
   logic [23:0]         s1_press_ff;
   logic signed [24:0]  s1_dt_ff;
   logic signed [24:0]  dt_raw;
   logic signed [24:0]  dt_in;
   logic                s1_ready;

   logic                s2_valid_ff;
   ptc_pkg::prod_type   s2_item_ff;
   ptc_pkg::prod_type   s2_item_in;
   logic                s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // difference from the reference, reference is word times 256
   always_comb begin
      dt_raw = $signed({1'b0, temperature_raw}) - $signed({1'b0, cal.ref_temp, 8'b0});
      if (dt_raw < ptc_pkg::DT_MIN) begin
         dt_in = ptc_pkg::DT_MIN;
      end else if (dt_raw > ptc_pkg::DT_MAX) begin
         dt_in = ptc_pkg::DT_MAX;
      end else begin
         dt_in = dt_raw;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready && in_valid) begin
         s1_press_ff <= pressure_raw;
         s1_dt_ff    <= dt_in;
      end
   end

   // tempco products
   always_comb begin
      s2_item_in.pressure_raw = s1_press_ff;
      s2_item_in.prod_temp    = s1_dt_ff * $signed({1'b0, cal.temp_coef});
      s2_item_in.prod_off     = s1_dt_ff * $signed({1'b0, cal.offset_tempco});
      s2_item_in.prod_sens    = s1_dt_ff * $signed({1'b0, cal.sens_tempco});
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

endmodule

@@ rtl/core/ptc_scale.sv @@
// temperature, offset and sensitivity scaling with limits
module ptc_scale (
   input  logic                clock,
   input  logic                reset,
   input  ptc_pkg::cal_type    cal,
   input  logic                in_valid,
   output logic                in_ready,
   input  ptc_pkg::prod_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output ptc_pkg::scale_type  out_item
);

   logic                s3_valid_ff;
   ptc_pkg::scale_type  s3_item_ff;
   ptc_pkg::scale_type  s3_item_in;
   logic signed [19:0]  temp_sum;
   logic signed [36:0]  off_sum;
   logic signed [35:0]  sens_sum;

   assign in_ready = !s3_valid_ff || out_ready;

   always_comb begin
      // temperature: base plus floor of product over 2^23
      temp_sum = $signed({in_item.prod_temp[41], in_item.prod_temp[41:23]}) + ptc_pkg::TEMP_BASE;
      // offset: base times 2^16 plus floor of product over 2^7
      off_sum  = $signed({5'b0, cal.offset_base, 16'b0})
               + $signed({{2{in_item.prod_off[41]}}, in_item.prod_off[41:7]});
      // sensitivity: base times 2^15 plus floor of product over 2^8
      sens_sum = $signed({5'b0, cal.sens_base, 15'b0})
               + $signed({{2{in_item.prod_sens[41]}}, in_item.prod_sens[41:8]});

      s3_item_in.pressure_raw = in_item.pressure_raw;

      if (temp_sum < ptc_pkg::TEMP_OUT_MIN) begin
         s3_item_in.temp_centideg = ptc_pkg::TEMP_OUT_MIN[17:0];
      end else if (temp_sum > ptc_pkg::TEMP_OUT_MAX) begin
         s3_item_in.temp_centideg = ptc_pkg::TEMP_OUT_MAX[17:0];
      end else begin
         s3_item_in.temp_centideg = temp_sum[17:0];
      end

      if (off_sum < ptc_pkg::OFF_MIN) begin
         s3_item_in.off = ptc_pkg::OFF_MIN[35:0];
      end else if (off_sum > ptc_pkg::OFF_MAX) begin
         s3_item_in.off = ptc_pkg::OFF_MAX[35:0];
      end else begin
         s3_item_in.off = off_sum[35:0];
      end

      if (sens_sum < ptc_pkg::SENS_MIN) begin
         s3_item_in.sens = ptc_pkg::SENS_MIN[34:0];
      end else if (sens_sum > ptc_pkg::SENS_MAX) begin
         s3_item_in.sens = ptc_pkg::SENS_MAX[34:0];
      end else begin
         s3_item_in.sens = sens_sum[34:0];
      end
   end

   // stage 3 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s3_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

@@ rtl/core/ptc_press.sv @@
// pressure product in two halves, recombine, remove offset and limit
module ptc_press (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ptc_pkg::scale_type  in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [17:0]  temp_centideg,
   output logic signed [24:0]  pressure_comp
);

   // stage 4: partial products
   logic                s4_valid_ff;
   logic [40:0]         s4_lo_ff;
   logic signed [42:0]  s4_hi_ff;
   logic signed [35:0]  s4_off_ff;
   logic signed [17:0]  s4_temp_ff;
   logic                s4_ready;

   // stage 5: full product over 2^21
   logic                s5_valid_ff;
   logic signed [38:0]  s5_sh_ff;
   logic signed [35:0]  s5_off_ff;
   logic signed [17:0]  s5_temp_ff;
   logic signed [59:0]  full_prod;
   logic                s5_ready;

   // stage 6: result register
   logic                s6_valid_ff;
   logic signed [24:0]  s6_press_ff;
   logic signed [24:0]  s6_press_in;
   logic signed [17:0]  s6_temp_ff;
   logic signed [39:0]  diff;
   logic signed [26:0]  p_full;
   logic                s6_ready;

   assign s6_ready = !s6_valid_ff || out_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   // low half unsigned, high half signed
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= in_valid;
      end
      if (s4_ready && in_valid) begin
         s4_lo_ff   <= in_item.pressure_raw * in_item.sens[16:0];
         s4_hi_ff   <= $signed({1'b0, in_item.pressure_raw}) * $signed(in_item.sens[34:17]);
         s4_off_ff  <= in_item.off;
         s4_temp_ff <= in_item.temp_centideg;
      end
   end

   // recombine halves
   assign full_prod = $signed({s4_hi_ff[42], s4_hi_ff, 16'b0} << 1)
                    + $signed({19'b0, s4_lo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (s5_ready && s4_valid_ff) begin
         s5_sh_ff   <= full_prod[59:21];
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
      end
   end

   // subtract offset, floor over 2^13, limit to the output field
   always_comb begin
      diff   = $signed({s5_sh_ff[38], s5_sh_ff})
             - $signed({{4{s5_off_ff[35]}}, s5_off_ff});
      p_full = diff[39:13];
      if (p_full < ptc_pkg::PRESS_OUT_MIN) begin
         s6_press_in = ptc_pkg::PRESS_OUT_MIN[24:0];
      end else if (p_full > ptc_pkg::PRESS_OUT_MAX) begin
         s6_press_in = ptc_pkg::PRESS_OUT_MAX[24:0];
      end else begin
         s6_press_in = p_full[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (s6_ready) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (s6_ready && s5_valid_ff) begin
         s6_press_ff <= s6_press_in;
         s6_temp_ff  <= s5_temp_ff;
      end
   end

   assign out_valid     = s6_valid_ff;
   assign temp_centideg = s6_temp_ff;
   assign pressure_comp = s6_press_ff;

endmodule
